>>> src/bwxp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bwxp_pkg;

  localparam int NumPlaneInputs = 8;
  localparam int WordW          = 64;
  localparam int ByteW          = 8;
  localparam int BytesPerWord   = WordW / ByteW;
  localparam int PopW           = $clog2(WordW + 1);
  localparam int ValidBytesW    = 4;
  localparam int ScoreW         = 23;
  localparam int PlaneCountW    = 4;
  localparam int QueueDepth     = 2;

  localparam int MaxWordsDefault  = 512;
  localparam int MaxPlanesDefault = 8;

  localparam logic [PlaneCountW-1:0] PlaneCountReset = PlaneCountW'(8);

  typedef logic [WordW-1:0] word_t;
  typedef logic [PopW-1:0]  pop_t;

  // One classified transaction as it waits between the front and back parts.
  typedef struct packed {
    pop_t [NumPlaneInputs-1:0] pops;
    logic                      ovf;
    logic                      last;
  } entry_t;

endpackage
`default_nettype wire

>>> src/bwxp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bwxp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [bwxp_pkg::WordW-1:0]             stored_word;
  logic [bwxp_pkg::WordW-1:0]             plane0_word;
  logic [bwxp_pkg::WordW-1:0]             plane1_word;
  logic [bwxp_pkg::WordW-1:0]             plane2_word;
  logic [bwxp_pkg::WordW-1:0]             plane3_word;
  logic [bwxp_pkg::WordW-1:0]             plane4_word;
  logic [bwxp_pkg::WordW-1:0]             plane5_word;
  logic [bwxp_pkg::WordW-1:0]             plane6_word;
  logic [bwxp_pkg::WordW-1:0]             plane7_word;
  logic [bwxp_pkg::ValidBytesW-1:0]       valid_bytes;
  logic                                   last_word;

  modport source (
    output valid, stored_word, plane0_word, plane1_word, plane2_word, plane3_word,
           plane4_word, plane5_word, plane6_word, plane7_word, valid_bytes, last_word,
    input  ready
  );
  modport sink (
    input  valid, stored_word, plane0_word, plane1_word, plane2_word, plane3_word,
           plane4_word, plane5_word, plane6_word, plane7_word, valid_bytes, last_word,
    output ready
  );
endinterface

interface bwxp_out_if;
  logic                         valid;
  logic                         ready;
  logic [bwxp_pkg::ScoreW-1:0]  score;
  logic                         overflow;

  modport source (output valid, score, overflow, input ready);
  modport sink   (input valid, score, overflow, output ready);
endinterface
`default_nettype wire

>>> src/bwxp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bwxp_front #(
  parameter int MAX_WORDS = bwxp_pkg::MaxWordsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  bwxp_in_if.sink              in_ch,
  input  wire logic            q_ready,
  output logic                 push,
  output bwxp_pkg::entry_t     push_entry
);

  localparam int WordCntW = $clog2(MAX_WORDS + 1);

  logic [WordCntW-1:0]                           word_count;
  logic                                          counted;
  logic [bwxp_pkg::WordW-1:0]                    mask;
  bwxp_pkg::word_t [bwxp_pkg::NumPlaneInputs-1:0] planes;

  assign planes = {in_ch.plane7_word, in_ch.plane6_word, in_ch.plane5_word,
                   in_ch.plane4_word, in_ch.plane3_word, in_ch.plane2_word,
                   in_ch.plane1_word, in_ch.plane0_word};

  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid & in_ch.ready;
  assign counted     = (word_count < WordCntW'(MAX_WORDS));

  always_comb begin
    for (int b = 0; b < bwxp_pkg::BytesPerWord; b++) begin
      mask[b*bwxp_pkg::ByteW +: bwxp_pkg::ByteW] =
        {bwxp_pkg::ByteW{bwxp_pkg::ValidBytesW'(b) < in_ch.valid_bytes}};
    end
  end

  // Words past the limit add nothing and flag overflow.
  always_comb begin
    for (int p = 0; p < bwxp_pkg::NumPlaneInputs; p++) begin
      push_entry.pops[p] = counted ?
        bwxp_pkg::PopW'($countones((in_ch.stored_word ^ planes[p]) & mask)) : '0;
    end
    push_entry.ovf  = ~counted;
    push_entry.last = in_ch.last_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (push) begin
      if (in_ch.last_word) begin
        word_count <= '0;
      end else if (counted) begin
        word_count <= word_count + WordCntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/bwxp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bwxp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire bwxp_pkg::entry_t  push_entry,
  output logic                   push_ready,
  output logic                   pop_valid,
  output bwxp_pkg::entry_t       pop_entry,
  input  wire logic              pop
);

  localparam int PtrW = $clog2(bwxp_pkg::QueueDepth);
  localparam int CntW = $clog2(bwxp_pkg::QueueDepth + 1);

  bwxp_pkg::entry_t  mem [bwxp_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   fill;

  assign push_ready = (fill < CntW'(bwxp_pkg::QueueDepth));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(bwxp_pkg::QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(bwxp_pkg::QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CntW'(1);
        2'b01:   fill <= fill - CntW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/bwxp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bwxp_back #(
  parameter int MAX_WORDS  = bwxp_pkg::MaxWordsDefault,
  parameter int MAX_PLANES = bwxp_pkg::MaxPlanesDefault
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               q_valid,
  input  wire bwxp_pkg::entry_t                   q_entry,
  output logic                                    pop,
  input  wire logic [bwxp_pkg::PlaneCountW-1:0]   plane_count,
  bwxp_out_if.source                              out_ch
);

  localparam int CntW = $clog2(bwxp_pkg::WordW * MAX_WORDS + 1);
  localparam int SumW = (CntW + MAX_PLANES > bwxp_pkg::ScoreW) ?
                        CntW + MAX_PLANES : bwxp_pkg::ScoreW;

  logic [MAX_PLANES-1:0][CntW-1:0] acc;
  logic [MAX_PLANES-1:0][CntW-1:0] acc_sum;
  logic [MAX_PLANES-1:0][CntW-1:0] fin;
  logic                            ovf_seen;
  logic                            fin_ovf;
  logic                            fin_valid;
  logic                            fin_free;
  logic                            out_load;
  logic                            out_valid;
  logic [bwxp_pkg::PlaneCountW-1:0] active;
  logic [bwxp_pkg::ScoreW-1:0]     score_next;
  logic [SumW-1:0]                 term;

  assign out_load = fin_valid & (~out_valid | out_ch.ready);
  assign fin_free = ~fin_valid | out_load;
  assign pop      = q_valid & (~q_entry.last | fin_free);
  assign out_ch.valid = out_valid;

  always_comb begin
    for (int p = 0; p < MAX_PLANES; p++) begin
      acc_sum[p] = acc[p] + CntW'(q_entry.pops[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      ovf_seen <= 1'b0;
    end else if (pop) begin
      if (q_entry.last) begin
        acc      <= '0;
        ovf_seen <= 1'b0;
      end else begin
        acc      <= acc_sum;
        ovf_seen <= ovf_seen | q_entry.ovf;
      end
    end
  end

  // Final counts of a finished vector wait here for the score stage.
  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      fin     <= acc_sum;
      fin_ovf <= ovf_seen | q_entry.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (pop && q_entry.last) begin
      fin_valid <= 1'b1;
    end else if (out_load) begin
      fin_valid <= 1'b0;
    end
  end

  always_comb begin
    if (plane_count == '0) begin
      active = bwxp_pkg::PlaneCountW'(1);
    end else if (plane_count > bwxp_pkg::PlaneCountW'(MAX_PLANES)) begin
      active = bwxp_pkg::PlaneCountW'(MAX_PLANES);
    end else begin
      active = plane_count;
    end
  end

  // Weight plane p by 2^p; result wraps at the score width.
  always_comb begin
    score_next = '0;
    term       = '0;
    for (int p = 0; p < MAX_PLANES; p++) begin
      term = SumW'(fin[p]) << p;
      if (bwxp_pkg::PlaneCountW'(p) < active) begin
        score_next = score_next + term[bwxp_pkg::ScoreW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.score    <= score_next;
      out_ch.overflow <= fin_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> src/bitplane_weighted_xor_popcount.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-plane weighted XOR popcount.
// in_ch carries one transaction per stored 64-bit word: the stored word, the
// matching word of each of the eight query planes, the number of valid low
// bytes and a last flag. out_ch carries one transaction (score, overflow) per
// vector, after the transaction marked last. cfg_we/cfg_wdata write the
// number of planes weighted into the score (0 acts as 1, large values clamp).
// Throughput: one input transaction per cycle while the queue has room, set
// by the combinational popcount in the front part and the accumulate in the
// back part. A last transaction is written into the queue when accepted;
// its result is then registered in the final stage and after that in the
// score register.
// Reset clears all counters and sets the plane count to eight.
// When the receiver stalls, the result register holds, one more finished
// vector waits in the final stage, the two-entry queue fills, and only then
// does in_ch.ready drop. Words past MAX_WORDS in one vector add nothing and
// set the overflow flag of that vector's result.
module bitplane_weighted_xor_popcount #(
  parameter int MAX_WORDS  = bwxp_pkg::MaxWordsDefault,
  parameter int MAX_PLANES = bwxp_pkg::MaxPlanesDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  bwxp_in_if.sink                                in_ch,
  bwxp_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [bwxp_pkg::PlaneCountW-1:0]  cfg_wdata
);

  logic [bwxp_pkg::PlaneCountW-1:0] plane_count;
  logic                             q_ready;
  logic                             push;
  bwxp_pkg::entry_t                 push_entry;
  logic                             q_valid;
  bwxp_pkg::entry_t                 q_entry;
  logic                             pop;

  // Hold the plane count until the next configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= bwxp_pkg::PlaneCountReset;
    end else if (cfg_we) begin
      plane_count <= cfg_wdata;
    end
  end

  // Front: accept, mask and popcount each plane, track the word limit.
  bwxp_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: decouple classification from accumulation.
  bwxp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (pop)
  );

  // Back: accumulate per plane, weight and emit on the last word.
  bwxp_back #(
    .MAX_WORDS  (MAX_WORDS),
    .MAX_PLANES (MAX_PLANES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .pop         (pop),
    .plane_count (plane_count),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

>>> sim/bitplane_weighted_xor_popcount_tb.sv
`timescale 1ns / 1ps
module bitplane_weighted_xor_popcount_tb;

  localparam int MaxWords  = bwxp_pkg::MaxWordsDefault;
  localparam int MaxPlanes = bwxp_pkg::MaxPlanesDefault;

  // One input transaction: the stored word, the eight query plane words,
  // how many low bytes count, and the end-of-vector mark.
  typedef struct packed {
    bwxp_pkg::word_t                                stored;
    bwxp_pkg::word_t [bwxp_pkg::NumPlaneInputs-1:0] planes;
    logic  [bwxp_pkg::ValidBytesW-1:0]              vbytes;
    logic                                           last;
  } word_item_t;

  // One output transaction as the block should present it.
  typedef struct packed {
    logic [bwxp_pkg::ScoreW-1:0] score;
    logic                        overflow;
  } score_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [bwxp_pkg::PlaneCountW-1:0] cfg_wdata = '0;

  bwxp_in_if  in_ch ();
  bwxp_out_if out_ch ();

  bitplane_weighted_xor_popcount dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the block state: exact per-plane differing-bit counts, the
  // number of words taken into the current vector, its overflow flag and the
  // plane count register.
  int unsigned                      plane_diff_cnt [bwxp_pkg::NumPlaneInputs];
  int unsigned                      words_counted;
  logic                             ovf_flag;
  logic [bwxp_pkg::PlaneCountW-1:0] planes_cfg;

  // Scores still owed by the block, oldest first.
  score_result_t score_expect_q [$];

  int mismatches    = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int stall_hold    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("bitplane_weighted_xor_popcount verification failed");
    $finish;
  end

  // Receiver: honor a requested long hold first, otherwise drop ready at
  // random according to the current idle rate.
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_ch.ready = 1'b0;
      stall_hold = stall_hold - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // Compare every accepted output transaction with the oldest expected score.
  always @(posedge clk) begin
    score_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (score_expect_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: score %0d overflow %0b",
                                out_ch.score, out_ch.overflow));
      end else begin
        want = score_expect_q.pop_front();
        if (out_ch.score !== want.score)
          flag_mismatch($sformatf("score: expected %0d, got %0d",
                                  want.score, out_ch.score));
        if (out_ch.overflow !== want.overflow)
          flag_mismatch($sformatf("overflow: expected %0b, got %0b",
                                  want.overflow, out_ch.overflow));
      end
    end
  end

  task automatic clear_vector_state();
    foreach (plane_diff_cnt[p]) plane_diff_cnt[p] = 0;
    words_counted = 0;
    ovf_flag = 1'b0;
  endtask

  // Fold one accepted word into the mirrored counters; on the last word of a
  // vector, form the weighted score and queue it.
  task automatic accumulate_word(input word_item_t w);
    bwxp_pkg::word_t keep;
    int unsigned     n_act;
    logic [31:0]     total;
    score_result_t   r;
    // Zero valid bytes keeps nothing; eight or more keeps the whole word.
    if (w.vbytes >= 8) keep = '1;
    else keep = (bwxp_pkg::word_t'(1) << (w.vbytes * 8)) - bwxp_pkg::word_t'(1);
    // Past the word limit, nothing is added and the vector is marked.
    if (words_counted >= MaxWords) begin
      ovf_flag = 1'b1;
    end else begin
      for (int p = 0; p < bwxp_pkg::NumPlaneInputs; p++)
        plane_diff_cnt[p] += $countones((w.stored ^ w.planes[p]) & keep);
      words_counted++;
    end
    if (w.last) begin
      // A plane count of zero acts as one; large values clamp to the maximum.
      if (planes_cfg == 0) n_act = 1;
      else if (planes_cfg > MaxPlanes) n_act = MaxPlanes;
      else n_act = planes_cfg;
      total = '0;
      for (int p = 0; p < n_act; p++) total += plane_diff_cnt[p] << p;
      r.score = total[bwxp_pkg::ScoreW-1:0];
      r.overflow = ovf_flag;
      score_expect_q.push_back(r);
      clear_vector_state();
    end
  endtask

  // Offer one transaction: idle at random first, then hold it until taken.
  task automatic send_word(input word_item_t w);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.stored_word = w.stored;
    in_ch.plane0_word = w.planes[0];
    in_ch.plane1_word = w.planes[1];
    in_ch.plane2_word = w.planes[2];
    in_ch.plane3_word = w.planes[3];
    in_ch.plane4_word = w.planes[4];
    in_ch.plane5_word = w.planes[5];
    in_ch.plane6_word = w.planes[6];
    in_ch.plane7_word = w.planes[7];
    in_ch.valid_bytes = w.vbytes;
    in_ch.last_word   = w.last;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    accumulate_word(w);
  endtask

  // Drop valid, wait for every owed score, then let the pipeline empty out
  // so that trailing non-last words are fully absorbed.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (score_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_plane_count(input logic [bwxp_pkg::PlaneCountW-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    planes_cfg = v;
  endtask

  // Random word: planes are either equal to the stored word, its inverse,
  // one bit away, or fully random, so counts spread over the whole range.
  function automatic word_item_t make_word(input logic last);
    word_item_t w;
    w.stored = {$urandom, $urandom};
    for (int p = 0; p < bwxp_pkg::NumPlaneInputs; p++) begin
      case ($urandom_range(5))
        0:       w.planes[p] = w.stored;
        1:       w.planes[p] = ~w.stored;
        2:       w.planes[p] = w.stored ^ (bwxp_pkg::word_t'(1) << $urandom_range(63));
        default: w.planes[p] = {$urandom, $urandom};
      endcase
    end
    if ($urandom_range(3) == 0) w.vbytes = bwxp_pkg::ValidBytesW'($urandom_range(15));
    else w.vbytes = bwxp_pkg::ValidBytesW'($urandom_range(1, 8));
    w.last = last;
    return w;
  endfunction

  function automatic word_item_t fixed_word(input bwxp_pkg::word_t s,
                                            input bwxp_pkg::word_t pl,
                                            input int vb, input logic last);
    word_item_t w;
    w.stored = s;
    for (int p = 0; p < bwxp_pkg::NumPlaneInputs; p++) w.planes[p] = pl;
    w.vbytes = bwxp_pkg::ValidBytesW'(vb);
    w.last = last;
    return w;
  endfunction

  // All-different, all-equal and checkerboard words, plus a two-word vector.
  task automatic test_field_extremes();
    word_item_t w;
    send_word(fixed_word('0, '1, 8, 1'b1));
    send_word(fixed_word('1, '1, 8, 1'b1));
    w = fixed_word({16{4'hA}}, {16{4'h5}}, 8, 1'b1);
    for (int p = 1; p < bwxp_pkg::NumPlaneInputs; p += 2) w.planes[p] = {16{4'hA}};
    send_word(w);
    send_word(fixed_word('1, '0, 8, 1'b0));
    send_word(fixed_word('0, '1, 8, 1'b1));
  endtask

  // Zero bytes, partial words, a full word, and values above eight.
  task automatic test_valid_byte_counts();
    int vbs[6] = '{0, 1, 7, 8, 9, 15};
    word_item_t w;
    foreach (vbs[i]) begin
      w = make_word(1'b1);
      w.vbytes = bwxp_pkg::ValidBytesW'(vbs[i]);
      send_word(w);
    end
  endtask

  // Sweep the plane count, including zero and values past the maximum.
  task automatic test_plane_count_settings();
    int settings[7] = '{0, 1, 2, 4, 8, 9, 15};
    foreach (settings[i]) begin
      write_plane_count(bwxp_pkg::PlaneCountW'(settings[i]));
      send_word(make_word(1'b0));
      send_word(make_word(1'b1));
    end
  endtask

  // One word past the limit at full difference: the counted words give the
  // largest score, the extra word sets overflow; the next vector starts clean.
  task automatic test_word_limit();
    write_plane_count(bwxp_pkg::PlaneCountW'(8));
    for (int i = 0; i < MaxWords + 1; i++)
      send_word(fixed_word('0, '1, 8, i == MaxWords));
    send_word(make_word(1'b0));
    send_word(make_word(1'b1));
  endtask

  // Hold the receiver off for a long stretch while single-word vectors keep
  // coming, so the block fills and stalls its input; then pause until drained.
  task automatic test_backpressure();
    int saved_src;
    saved_src = src_idle_pct;
    src_idle_pct = 0;
    stall_hold = 80;
    for (int i = 0; i < 12; i++) send_word(make_word(1'b1));
    wait_idle();
    src_idle_pct = saved_src;
  endtask

  // Mostly short vectors, now and then a longer one, until n words are sent.
  task automatic run_random_phase(input int src_pct, input int sink_pct,
                                  input logic [bwxp_pkg::PlaneCountW-1:0] planes,
                                  input int n_words);
    int sent;
    int len;
    write_plane_count(planes);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(9) == 0) len = $urandom_range(7, 40);
      else len = $urandom_range(1, 6);
      if (len > n_words - sent) len = n_words - sent;
      for (int i = 0; i < len; i++) send_word(make_word(i == len - 1));
      sent += len;
    end
  endtask

  task automatic test_random_vectors();
    run_random_phase(11, 63, bwxp_pkg::PlaneCountW'($urandom_range(15)), 8);
    run_random_phase(63, 11, bwxp_pkg::PlaneCountW'(1), 8);
    run_random_phase(0, 0, bwxp_pkg::PlaneCountW'($urandom_range(15)), 8);
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.stored_word = '0;
    in_ch.plane0_word = '0;
    in_ch.plane1_word = '0;
    in_ch.plane2_word = '0;
    in_ch.plane3_word = '0;
    in_ch.plane4_word = '0;
    in_ch.plane5_word = '0;
    in_ch.plane6_word = '0;
    in_ch.plane7_word = '0;
    in_ch.valid_bytes = '0;
    in_ch.last_word   = 1'b0;
    out_ch.ready      = 1'b0;
    clear_vector_state();
    planes_cfg = bwxp_pkg::PlaneCountReset;

    // Hold reset, then release it away from the sampling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle_pct = 11;
    sink_idle_pct = 63;
    test_field_extremes();
    test_valid_byte_counts();
    test_plane_count_settings();
    test_word_limit();
    test_backpressure();
    test_random_vectors();

    wait_idle();
    repeat (10) @(posedge clk);
    if (score_expect_q.size() != 0) mismatches += score_expect_q.size();
    if (mismatches == 0) begin
      $display("bitplane_weighted_xor_popcount verification clean");
    end else begin
      $display("bitplane_weighted_xor_popcount verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/bwxp_pkg.sv
src/bwxp_if.sv
src/bwxp_front.sv
src/bwxp_queue.sv
src/bwxp_back.sv
src/bitplane_weighted_xor_popcount.sv
sim/bitplane_weighted_xor_popcount_tb.sv
